[rtl/assert_macros.svh]
// assertion macros shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, c, r, a, b) \
  lbl: assert property (@(posedge c) disable iff (r) (a) |-> (b)) \
    else $error("implication check failed");

// next-cycle implication
`define ASSERT_NXT(lbl, c, r, a, b) \
  lbl: assert property (@(posedge c) disable iff (r) (a) |=> (b)) \
    else $error("next-cycle check failed");

`endif

[rtl/gda_pkg.sv]
package gda_pkg;

  localparam int YEAR_W  = 12;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int OFF_W   = 16;
  localparam int LAST_YEAR_DEFAULT = 3000;

  typedef struct packed {
    logic [YEAR_W-1:0]  start_year;
    logic [MONTH_W-1:0] start_month;
    logic [DAY_W-1:0]   start_day;
    logic [OFF_W-1:0]   offset_days;
  } item_t;

  typedef struct packed {
    logic               found;
    logic [YEAR_W-1:0]  result_year;
    logic [MONTH_W-1:0] result_month;
    logic [DAY_W-1:0]   result_day;
  } result_t;

  typedef logic [2:0] pc_t;

  // step addresses of the program
  localparam pc_t ST_LOAD = 3'd0;
  localparam pc_t ST_QMUL = 3'd1;
  localparam pc_t ST_MOD  = 3'd2;
  localparam pc_t ST_NORM = 3'd3;
  localparam pc_t ST_CHK  = 3'd4;
  localparam pc_t ST_STEP = 3'd5;
  localparam pc_t ST_DONE = 3'd6;
  localparam pc_t ST_FAIL = 3'd7;

  typedef enum logic [2:0] {
    OP_LOAD, OP_QMUL, OP_MOD, OP_NORM, OP_CHK, OP_STEP, OP_DONE, OP_FAIL
  } op_t;

  typedef enum logic [2:0] {
    C_NEXT, C_OVER, C_MORE, C_WAIT_IN, C_WAIT_OUT
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ctrl_t;

  typedef struct packed {
    logic over;  // year beyond the limit
    logic more;  // offset reaches past the current month
  } status_t;

  localparam logic [MONTH_W-1:0] FEB = 4'd2;
  localparam logic [MONTH_W-1:0] APR = 4'd4;
  localparam logic [MONTH_W-1:0] JUN = 4'd6;
  localparam logic [MONTH_W-1:0] SEP = 4'd9;
  localparam logic [MONTH_W-1:0] NOV = 4'd11;
  localparam logic [MONTH_W-1:0] DEC = 4'd12;

  // microcode rom
  function automatic ctrl_t ucode(pc_t pc);
    ctrl_t w;
    case (pc)
      ST_LOAD: w = '{op: OP_LOAD, cond: C_WAIT_IN,  target: ST_QMUL};
      ST_QMUL: w = '{op: OP_QMUL, cond: C_NEXT,     target: ST_MOD};
      ST_MOD:  w = '{op: OP_MOD,  cond: C_NEXT,     target: ST_NORM};
      ST_NORM: w = '{op: OP_NORM, cond: C_NEXT,     target: ST_CHK};
      ST_CHK:  w = '{op: OP_CHK,  cond: C_OVER,     target: ST_FAIL};
      ST_STEP: w = '{op: OP_STEP, cond: C_MORE,     target: ST_CHK};
      ST_DONE: w = '{op: OP_DONE, cond: C_WAIT_OUT, target: ST_LOAD};
      ST_FAIL: w = '{op: OP_FAIL, cond: C_WAIT_OUT, target: ST_LOAD};
      default: w = '{op: OP_LOAD, cond: C_WAIT_IN,  target: ST_QMUL};
    endcase
    return w;
  endfunction

  function automatic logic [DAY_W-1:0] month_len(logic [MONTH_W-1:0] m, logic leap);
    logic [DAY_W-1:0] n;
    case (m)
      APR, JUN, SEP, NOV: n = 5'd30;
      FEB:                n = leap ? 5'd29 : 5'd28;
      default:            n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

[rtl/gregorian_date_add_days.sv]
// channel | dir | handshake                   | word
// item    | in  | item_valid / item_stall     | gda_pkg::item_t
// result  | out | result_valid / result_stall | gda_pkg::result_t
//
// one item at a time under an 8-step microcode program; month by month walk
// once accepted, the item runs the quotient, mod and normalise steps, then the month loop
// the month loop (check step plus advance step) runs for each month reached
// rst is synchronous; it clears the step counter and result valid
// a stalled result holds; the next item is taken while it waits
module gregorian_date_add_days #(
  parameter int LAST_YEAR = gda_pkg::LAST_YEAR_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  gda_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output gda_pkg::result_t result
);

  gda_pkg::pc_t     pc;
  gda_pkg::pc_t     pc_next;
  gda_pkg::ctrl_t   ctl;
  gda_pkg::status_t sts;
  logic             accept;
  logic             out_free;
  logic             emit;
  logic [gda_pkg::YEAR_W-1:0]  y;
  logic [gda_pkg::MONTH_W-1:0] m;
  logic [gda_pkg::DAY_W-1:0]   d;

  assign ctl        = gda_pkg::ucode(pc);
  assign item_stall = (ctl.op != gda_pkg::OP_LOAD);
  assign accept     = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;
  assign emit       = ((ctl.op == gda_pkg::OP_DONE) || (ctl.op == gda_pkg::OP_FAIL)) &&
                      out_free;

  always_comb begin
    case (ctl.cond)
      gda_pkg::C_NEXT:     pc_next = pc + 3'd1;
      gda_pkg::C_OVER:     pc_next = sts.over ? ctl.target : pc + 3'd1;
      gda_pkg::C_MORE:     pc_next = sts.more ? ctl.target : pc + 3'd1;
      gda_pkg::C_WAIT_IN:  pc_next = accept ? ctl.target : pc;
      gda_pkg::C_WAIT_OUT: pc_next = out_free ? ctl.target : pc;
      default:             pc_next = gda_pkg::ST_LOAD;
    endcase
  end

  gda_dp #(
    .LAST_YEAR (LAST_YEAR)
  ) u_dp (
    .clk       (clk),
    .load      (accept),
    .item      (item),
    .ctl       (ctl),
    .sts       (sts),
    .year_out  (y),
    .month_out (m),
    .day_out   (d)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pc           <= gda_pkg::ST_LOAD;
      result_valid <= 1'b0;
    end else begin
      pc <= pc_next;
      if (emit) begin
        result_valid <= 1'b1;
        if (ctl.op == gda_pkg::OP_DONE) begin
          result <= '{found: 1'b1, result_year: y, result_month: m, result_day: d};
        end else begin
          result <= '0;
        end
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/gda_dp.sv]
module gda_dp #(
  parameter int LAST_YEAR = gda_pkg::LAST_YEAR_DEFAULT
) (
  input  logic              clk,
  input  logic              load,
  input  gda_pkg::item_t    item,
  input  gda_pkg::ctrl_t    ctl,
  output gda_pkg::status_t  sts,
  output logic [gda_pkg::YEAR_W-1:0]  year_out,
  output logic [gda_pkg::MONTH_W-1:0] month_out,
  output logic [gda_pkg::DAY_W-1:0]   day_out
);

  // one spare bit so a year past 4095 still compares as over the limit
  logic [gda_pkg::YEAR_W:0]    year;
  logic [gda_pkg::MONTH_W-1:0] month;
  logic [gda_pkg::DAY_W-1:0]   day;
  logic [gda_pkg::OFF_W-1:0]   rem;
  logic [8:0]                  quot;
  logic [4:0]                  ymod;   // year mod 25

  logic [gda_pkg::YEAR_W:0]    ny;
  logic [gda_pkg::MONTH_W-1:0] nm;
  logic [gda_pkg::DAY_W-1:0]   nd;
  logic                        leap;
  logic [gda_pkg::DAY_W-1:0]   mlen;
  logic [gda_pkg::DAY_W-1:0]   left;
  logic [23:0]                 prod;
  logic [gda_pkg::YEAR_W:0]    q25;
  logic [gda_pkg::YEAR_W:0]    r13;
  logic [4:0]                  ymod_inc;
  logic                        wrap;

  // start date cleanup for month zero, month past december and day zero
  always_comb begin
    ny = {1'b0, item.start_year};
    nm = item.start_month;
    nd = item.start_day;
    if (nm == '0) begin
      nm = 4'd1;
      nd = 5'd1;
    end else if (nm > gda_pkg::DEC) begin
      nm = 4'd1;
      nd = 5'd1;
      ny = ny + 13'd1;
    end
    if (nd == '0) nd = 5'd1;
  end

  // divisible by 400 is divisible by 16 and by 25
  assign leap = (year[1:0] == 2'b00) && ((ymod != '0) || (year[3:2] == 2'b00));
  assign mlen = gda_pkg::month_len(month, leap);
  assign left = mlen - day;

  // floor(y/25) within one below, via 1310/2^15
  assign prod = {11'b0, year} * 24'd1310;
  assign q25  = 13'({4'b0, quot} * 13'd25);
  assign r13  = year - q25;

  assign ymod_inc = (ymod == 5'd24) ? 5'd0 : ymod + 5'd1;
  assign wrap     = (month == gda_pkg::DEC);

  assign sts.over = year > 13'(LAST_YEAR);
  assign sts.more = rem > {11'b0, left};

  assign year_out  = year[gda_pkg::YEAR_W-1:0];
  assign month_out = month;
  assign day_out   = day;

  always_ff @(posedge clk) begin
    case (ctl.op)
      gda_pkg::OP_LOAD: begin
        if (load) begin
          year  <= ny;
          month <= nm;
          day   <= nd;
          rem   <= item.offset_days;
        end
      end
      gda_pkg::OP_QMUL: quot <= prod[23:15];
      gda_pkg::OP_MOD: begin
        if (r13 >= 13'd25) ymod <= 5'(r13 - 13'd25);
        else ymod <= 5'(r13);
      end
      gda_pkg::OP_NORM: begin
        if (day > mlen) begin
          day <= 5'd1;
          if (wrap) begin
            month <= 4'd1;
            year  <= year + 13'd1;
            ymod  <= ymod_inc;
          end else begin
            month <= month + 4'd1;
          end
        end
      end
      gda_pkg::OP_STEP: begin
        if (!sts.more) begin
          day <= day + rem[gda_pkg::DAY_W-1:0];
          rem <= '0;
        end else begin
          rem <= rem - {11'b0, left} - 16'd1;
          day <= 5'd1;
          if (wrap) begin
            month <= 4'd1;
            year  <= year + 13'd1;
            ymod  <= ymod_inc;
          end else begin
            month <= month + 4'd1;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

[rtl/gda_checker.sv]
`include "assert_macros.svh"

module gda_checker (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_stall,
  input gda_pkg::item_t   item,
  input logic             result_valid,
  input logic             result_stall,
  input gda_pkg::result_t result
);

  logic miss_clear;
  logic hit_sane;

  assign miss_clear = (result.result_year == '0) && (result.result_month == '0) &&
                      (result.result_day == '0);
  assign hit_sane   = (result.result_month >= 4'd1) && (result.result_month <= 4'd12) &&
                      (result.result_day >= 5'd1);

  // one word in flight on the input side
  `ASSERT_NXT(a_one_item, clk, rst, item_valid && !item_stall, item_stall)

  // a waiting input word holds still
  `ASSERT_NXT(a_item_hold, clk, rst, item_valid && item_stall, item_valid && $stable(item))

  `ASSERT_IMP(a_miss_zero, clk, rst, result_valid && !result.found, miss_clear)

  `ASSERT_IMP(a_hit_range, clk, rst, result_valid && result.found, hit_sane)

  `ASSERT_NXT(a_hold, clk, rst, result_valid && result_stall, result_valid && $stable(result))

endmodule

bind gregorian_date_add_days gda_checker u_gda_checker (.*);

[verif/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int YEAR_W            = gda_pkg::YEAR_W;
  localparam int MONTH_W           = gda_pkg::MONTH_W;
  localparam int DAY_W             = gda_pkg::DAY_W;
  localparam int OFF_W             = gda_pkg::OFF_W;
  localparam int LAST_YEAR_DEFAULT = gda_pkg::LAST_YEAR_DEFAULT;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             item_valid = 1'b0;
  logic             item_stall;
  gda_pkg::item_t   item = '0;
  logic             result_valid;
  logic             result_stall = 1'b0;
  gda_pkg::result_t result;

  bit               idling = 1'b1;
  int unsigned      errors = 0;
  gda_pkg::result_t expected_dates[$];

  gregorian_date_add_days u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("FAILURE");
    $finish;
  end

  function automatic int unsigned days_in_month(int unsigned y, int unsigned m);
    case (m)
      gda_pkg::APR, gda_pkg::JUN, gda_pkg::SEP, gda_pkg::NOV: return 30;
      gda_pkg::FEB: return ((y % 400 == 0) || (y % 100 != 0 && y % 4 == 0)) ? 29 : 28;
      default: return 31;
    endcase
  endfunction

  // date reached from the start date after the offset, walked month by month
  function automatic gda_pkg::result_t add_days(gda_pkg::item_t it);
    int unsigned      y, m, d, rem, left_days;
    bit               ok;
    gda_pkg::result_t r;
    y   = 32'(it.start_year);
    m   = 32'(it.start_month);
    d   = 32'(it.start_day);
    rem = 32'(it.offset_days);
    ok  = 1'b1;
    // month zero means jan 1, months past december mean jan 1 of next year
    if (m == 0) begin
      m = 1;
      d = 1;
    end else if (m > gda_pkg::DEC) begin
      m = 1;
      d = 1;
      y++;
    end
    if (d == 0) d = 1;
    // a day past the month end starts on the first of the next month
    if (d > days_in_month(y, m)) begin
      d = 1;
      m++;
      if (m > gda_pkg::DEC) begin
        m = 1;
        y++;
      end
    end
    if (y > LAST_YEAR_DEFAULT) ok = 1'b0;
    while (ok && rem > 0) begin
      left_days = days_in_month(y, m) - d;
      if (rem <= left_days) begin
        d += rem;
        rem = 0;
      end else begin
        rem -= left_days + 1;
        d = 1;
        m++;
        if (m > gda_pkg::DEC) begin
          m = 1;
          y++;
          if (y > LAST_YEAR_DEFAULT) ok = 1'b0;
        end
      end
    end
    r = '0;
    if (ok) begin
      r.found        = 1'b1;
      r.result_year  = YEAR_W'(y);
      r.result_month = MONTH_W'(m);
      r.result_day   = DAY_W'(d);
    end
    return r;
  endfunction

  function automatic gda_pkg::item_t random_date();
    gda_pkg::item_t it;
    int unsigned    pick;
    pick = $urandom_range(0, 99);
    if (pick < 10)
      it.start_year = YEAR_W'($urandom_range(LAST_YEAR_DEFAULT + 1, (1 << YEAR_W) - 1));
    else if (pick < 30)
      it.start_year = YEAR_W'($urandom_range(LAST_YEAR_DEFAULT - 180, LAST_YEAR_DEFAULT));
    else
      it.start_year = YEAR_W'($urandom_range(0, LAST_YEAR_DEFAULT));
    it.start_month = MONTH_W'(($urandom_range(0, 99) < 85) ? $urandom_range(1, 12)
                                                          : $urandom_range(0, 15));
    it.start_day   = DAY_W'(($urandom_range(0, 99) < 85) ? $urandom_range(1, 28)
                                                        : $urandom_range(0, 31));
    it.offset_days = OFF_W'(($urandom_range(0, 99) < 25) ? $urandom_range(0, 65535)
                                                        : $urandom_range(0, 1500));
    return it;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic send_date(input gda_pkg::item_t it);
    while (idling && $urandom_range(0, 99) < 32) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (item_stall);
    expected_dates = {expected_dates, add_days(it)};
  endtask

  task automatic send_ymd(input int y, input int m, input int d, input int off);
    gda_pkg::item_t it;
    it.start_year  = YEAR_W'(y);
    it.start_month = MONTH_W'(m);
    it.start_day   = DAY_W'(d);
    it.offset_days = OFF_W'(off);
    send_date(it);
  endtask

  task automatic test_plain_dates();
    send_ymd(2023, 1, 15, 0);
    send_ymd(2023, 1, 31, 1);
    send_ymd(1999, 12, 31, 1);
    send_ymd(2000, 2, 28, 1);
    send_ymd(1900, 2, 28, 1);
    // year zero counts as leap
    send_ymd(0, 2, 28, 1);
    send_ymd(0, 1, 1, 65535);
    send_ymd(2023, 3, 7, 365);
  endtask

  task automatic test_odd_starts();
    send_ymd(2023, 2, 30, 0);
    send_ymd(1900, 2, 29, 0);
    send_ymd(2000, 2, 29, 0);
    send_ymd(2023, 11, 31, 5);
    send_ymd(2023, 6, 0, 0);
    send_ymd(2023, 0, 17, 10);
    send_ymd(2023, 13, 5, 0);
    send_ymd(2023, 15, 31, 59);
    send_ymd(0, 0, 0, 0);
  endtask

  task automatic test_year_limit();
    send_ymd(3000, 12, 31, 0);
    send_ymd(3000, 12, 31, 1);
    send_ymd(3001, 1, 1, 0);
    send_ymd(4095, 15, 31, 65535);
    send_ymd(2999, 15, 1, 0);
    send_ymd(3000, 15, 1, 0);
    send_ymd(2900, 1, 1, 65535);
    send_ymd(4095, 0, 0, 0);
  endtask

  task automatic test_random_dates(input int count);
    repeat (count) send_date(random_date());
  endtask

  // back to back words with neither side holding off
  task automatic test_steady_stream(input int count);
    idling = 1'b0;
    repeat (count) send_date(random_date());
    idling = 1'b1;
  endtask

  always @(posedge clk) begin
    result_stall <= idling && ($urandom_range(0, 99) < 32);
  end

  always @(posedge clk) begin : check_results
    gda_pkg::result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_dates.size() == 0) begin
        report_mismatch("result word with no item outstanding");
      end else begin
        want = expected_dates.pop_front();
        if (result.found !== want.found)
          report_mismatch($sformatf("found %b, want %b", result.found, want.found));
        if (result.result_year !== want.result_year)
          report_mismatch($sformatf("year %0d, want %0d",
                                    result.result_year, want.result_year));
        if (result.result_month !== want.result_month)
          report_mismatch($sformatf("month %0d, want %0d",
                                    result.result_month, want.result_month));
        if (result.result_day !== want.result_day)
          report_mismatch($sformatf("day %0d, want %0d",
                                    result.result_day, want.result_day));
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_plain_dates();
    test_odd_starts();
    test_year_limit();
    test_random_dates(50);
    test_steady_stream(25);
    item_valid <= 1'b0;
    while (expected_dates.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
